### hw/rtl/bcms_pkg.sv
`default_nettype none

package bcms_pkg;

  localparam int POS_W      = 20;
  localparam int IDX_W      = 18;
  localparam int BYTE_W     = 8;
  localparam int TEXEL_W    = 16;
  localparam int LEVEL_W    = 16;
  localparam int REG_W      = 10;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int COLUMN_BITS_DEF   = 9;
  localparam int ROW_BITS_DEF      = 9;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [REG_W-1:0] COVER_COLUMNS_RST = 10'd512;
  localparam logic [REG_W-1:0] COVER_ROWS_RST    = 10'd512;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_index_e;

  // Pipeline stage positions.
  localparam int STG_FLOOR = 0;
  localparam int STG_WRAP  = 1;
  localparam int STG_ADDR  = 2;
  localparam int STG_TEXEL = 3;
  localparam int STG_LERP  = 4;
  localparam int STG_OUT   = 5;
  localparam int STAGES    = 6;

endpackage

`default_nettype wire

### hw/rtl/bcms_if.sv
`default_nettype none

interface bcms_item_if import bcms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [IDX_W-1:0]   texel_index;
  logic [BYTE_W-1:0]  woods_in;
  logic [BYTE_W-1:0]  wet_in;
  logic signed [POS_W-1:0] column_pos;
  logic signed [POS_W-1:0] row_pos;

  modport source (
    output valid, action, texel_index, woods_in, wet_in, column_pos, row_pos,
    input  ready
  );
  modport sink (
    input  valid, action, texel_index, woods_in, wet_in, column_pos, row_pos,
    output ready
  );
endinterface

interface bcms_result_if import bcms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] woods;
  logic [LEVEL_W-1:0] wetness;

  modport source (
    output valid, woods, wetness,
    input  ready
  );
  modport sink (
    input  valid, woods, wetness,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/bcms_cfg.sv
`default_nettype none

module bcms_cfg import bcms_pkg::*; #(
  parameter int COLUMN_BITS   = COLUMN_BITS_DEF,
  parameter int ROW_BITS      = ROW_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready,
  output logic [COLUMN_BITS:0]        cols,
  output logic [ROW_BITS-1:0]         rows_last,
  output logic [ROW_BITS+FRACTION_BITS:0] row_limit
);

  localparam int SUB_BITS = FRACTION_BITS + 1;
  localparam int MAX_BITS = (COLUMN_BITS > ROW_BITS) ? COLUMN_BITS : ROW_BITS;
  localparam int SIZE_W   = (MAX_BITS + 1 > REG_W) ? MAX_BITS + 1 : REG_W;

  logic [REG_W-1:0] columns_reg;
  logic [REG_W-1:0] rows_reg;
  logic [REG_W-1:0] wr_value;
  logic             wr_en;
  logic [ROW_BITS-1:0] rows_last_next;

  // A size of zero counts as one; anything above the map limit counts as the limit.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [REG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] ext;
    ext = SIZE_W'(v);
    if (ext == '0) begin
      return SIZE_W'(1);
    end else if (ext > lim) begin
      return lim;
    end
    return ext;
  endfunction

  assign wr_en    = psel && penable && pwrite;
  assign wr_value = pwdata[REG_W-1:0];
  assign pready   = 1'b1;
  assign rows_last_next =
    ROW_BITS'(clamp_size(wr_value, SIZE_W'(1) << ROW_BITS) - SIZE_W'(1));

  always_comb begin
    unique case (reg_index_e'(paddr[APB_ADDR_W-1]))
      REG_COLUMNS: prdata = APB_DATA_W'(columns_reg);
      REG_ROWS:    prdata = APB_DATA_W'(rows_reg);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_reg <= COVER_COLUMNS_RST;
      rows_reg    <= COVER_ROWS_RST;
      cols        <= (COLUMN_BITS+1)'(clamp_size(COVER_COLUMNS_RST,
                                                 SIZE_W'(1) << COLUMN_BITS));
      rows_last   <= ROW_BITS'(clamp_size(COVER_ROWS_RST, SIZE_W'(1) << ROW_BITS)
                               - SIZE_W'(1));
      row_limit   <= {ROW_BITS'(clamp_size(COVER_ROWS_RST, SIZE_W'(1) << ROW_BITS)
                                - SIZE_W'(1)), SUB_BITS'(0)};
    end else if (wr_en) begin
      unique case (reg_index_e'(paddr[APB_ADDR_W-1]))
        REG_COLUMNS: begin
          columns_reg <= wr_value;
          cols        <= (COLUMN_BITS+1)'(clamp_size(wr_value, SIZE_W'(1) << COLUMN_BITS));
        end
        REG_ROWS: begin
          rows_reg  <= wr_value;
          rows_last <= rows_last_next;
          row_limit <= {rows_last_next, SUB_BITS'(0)};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcms_coord.sv
`default_nettype none

module bcms_coord import bcms_pkg::*; #(
  parameter int COLUMN_BITS   = COLUMN_BITS_DEF,
  parameter int ROW_BITS      = ROW_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic [STAGES-1:0]                 adv,
  input  logic                              action,
  input  logic [IDX_W-1:0]                  texel_index,
  input  logic [BYTE_W-1:0]                 woods_in,
  input  logic [BYTE_W-1:0]                 wet_in,
  input  logic signed [POS_W-1:0]           column_pos,
  input  logic signed [POS_W-1:0]           row_pos,
  input  logic [COLUMN_BITS:0]              cols,
  input  logic [ROW_BITS-1:0]               rows_last,
  input  logic [ROW_BITS+FRACTION_BITS:0]   row_limit,
  output logic                              is_load,
  output logic [COLUMN_BITS+ROW_BITS-1:0]   addr00,
  output logic [COLUMN_BITS+ROW_BITS-1:0]   addr10,
  output logic [COLUMN_BITS+ROW_BITS-1:0]   addr01,
  output logic [COLUMN_BITS+ROW_BITS-1:0]   addr11,
  output logic [FRACTION_BITS:0]            frac_col,
  output logic [FRACTION_BITS:0]            frac_row,
  output logic [TEXEL_W-1:0]                texel_data
);

  localparam int SUB_BITS = FRACTION_BITS + 1;
  localparam int ADDR_W   = COLUMN_BITS + ROW_BITS;
  localparam int CI_W     = POS_W - SUB_BITS;
  localparam int RPOS_W   = ROW_BITS + SUB_BITS;
  localparam int RCMP_W   = ((RPOS_W > POS_W) ? RPOS_W : POS_W) + 1;
  localparam int WMAX     = (CI_W > COLUMN_BITS) ? CI_W : COLUMN_BITS;
  localparam int WRAP_W   = WMAX + 3;
  localparam int PROD_W   = ADDR_W + 1;

  // Stage 1: floor and fraction, row clamp.
  logic signed [CI_W-1:0]   col_int;
  logic signed [CI_W:0]     col_next;
  logic signed [RCMP_W-1:0] row_ext;
  logic signed [RCMP_W-1:0] limit_ext;
  logic [RPOS_W-1:0]        row_clamped;

  logic                     act1;
  logic [ADDR_W-1:0]        idx1;
  logic [TEXEL_W-1:0]       data1;
  logic signed [CI_W-1:0]   c0_1;
  logic signed [CI_W:0]     c1_1;
  logic [SUB_BITS-1:0]      fc1;
  logic [ROW_BITS-1:0]      r0_1;
  logic [SUB_BITS-1:0]      fr1;

  assign col_int   = column_pos[POS_W-1:SUB_BITS];
  assign col_next  = (CI_W+1)'(col_int) + (CI_W+1)'(1);
  assign row_ext   = RCMP_W'(row_pos);
  assign limit_ext = RCMP_W'(row_limit);

  always_comb begin
    if (row_ext[RCMP_W-1]) begin
      row_clamped = '0;
    end else if (row_ext > limit_ext) begin
      row_clamped = row_limit;
    end else begin
      row_clamped = RPOS_W'(row_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[STG_FLOOR]) begin
      act1  <= action;
      idx1  <= ADDR_W'(texel_index);
      data1 <= {wet_in, woods_in};
      c0_1  <= col_int;
      c1_1  <= col_next;
      fc1   <= column_pos[SUB_BITS-1:0];
      r0_1  <= row_clamped[RPOS_W-1:SUB_BITS];
      fr1   <= row_clamped[SUB_BITS-1:0];
    end
  end

  // Stage 2: column wrap around the cylinder, row below clamped.
  function automatic logic [COLUMN_BITS-1:0] wrap_col(input logic signed [WRAP_W-1:0] cc_in,
                                                      input logic [COLUMN_BITS:0] n);
    logic signed [WRAP_W-1:0] cc;
    logic signed [WRAP_W-1:0] span;
    span = WRAP_W'(n);
    cc   = cc_in;
    if (cc < 0) begin
      cc = cc + span;
    end else if (cc >= span) begin
      cc = cc - span;
    end
    if (cc < 0) begin
      cc = '0;
    end else if (cc >= span) begin
      cc = span - WRAP_W'(1);
    end
    return COLUMN_BITS'(cc);
  endfunction

  logic                     act2;
  logic [ADDR_W-1:0]        idx2;
  logic [TEXEL_W-1:0]       data2;
  logic [COLUMN_BITS-1:0]   x0_2;
  logic [COLUMN_BITS-1:0]   x1_2;
  logic [ROW_BITS-1:0]      y0_2;
  logic [ROW_BITS-1:0]      y1_2;
  logic [SUB_BITS-1:0]      fc2;
  logic [SUB_BITS-1:0]      fr2;

  always_ff @(posedge clk) begin
    if (adv[STG_WRAP]) begin
      act2  <= act1;
      idx2  <= idx1;
      data2 <= data1;
      x0_2  <= wrap_col(WRAP_W'(c0_1), cols);
      x1_2  <= wrap_col(WRAP_W'(c1_1), cols);
      y0_2  <= r0_1;
      y1_2  <= (r0_1 < rows_last) ? r0_1 + ROW_BITS'(1) : r0_1;
      fc2   <= fc1;
      fr2   <= fr1;
    end
  end

  // Stage 3: linear texel addresses.
  logic [PROD_W-1:0] base_top;
  logic [PROD_W-1:0] base_bot;

  assign base_top = PROD_W'(y0_2) * PROD_W'(cols);
  assign base_bot = PROD_W'(y1_2) * PROD_W'(cols);

  always_ff @(posedge clk) begin
    if (adv[STG_ADDR]) begin
      is_load    <= (act2 == ACT_LOAD);
      addr00     <= (act2 == ACT_LOAD) ? idx2 : ADDR_W'(base_top + PROD_W'(x0_2));
      addr10     <= ADDR_W'(base_top + PROD_W'(x1_2));
      addr01     <= ADDR_W'(base_bot + PROD_W'(x0_2));
      addr11     <= ADDR_W'(base_bot + PROD_W'(x1_2));
      frac_col   <= fc2;
      frac_row   <= fr2;
      texel_data <= data2;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcms_store.sv
`default_nettype none

module bcms_store import bcms_pkg::*; #(
  parameter int ADDR_W = COLUMN_BITS_DEF + ROW_BITS_DEF
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  addr00,
  input  logic [ADDR_W-1:0]  addr10,
  input  logic [ADDR_W-1:0]  addr01,
  input  logic [ADDR_W-1:0]  addr11,
  input  logic [TEXEL_W-1:0] wr_data,
  output logic [TEXEL_W-1:0] q00,
  output logic [TEXEL_W-1:0] q10,
  output logic [TEXEL_W-1:0] q01,
  output logic [TEXEL_W-1:0] q11
);

  localparam int DEPTH = 1 << ADDR_W;

  // Two identical copies, each with one write port and two read ports.
  // The first serves the upper texel row of a sample, the second the lower one.
  logic [TEXEL_W-1:0] copy_top [DEPTH];
  logic [TEXEL_W-1:0] copy_bot [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      copy_top[addr00] <= wr_data;
      copy_bot[addr00] <= wr_data;
    end
    if (rd_en) begin
      q00 <= copy_top[addr00];
      q10 <= copy_top[addr10];
      q01 <= copy_bot[addr01];
      q11 <= copy_bot[addr11];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcms_blend.sv
`default_nettype none

module bcms_blend import bcms_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic [STAGES-1:0]      adv,
  input  logic [FRACTION_BITS:0] frac_col,
  input  logic [FRACTION_BITS:0] frac_row,
  input  logic [TEXEL_W-1:0]     q00,
  input  logic [TEXEL_W-1:0]     q10,
  input  logic [TEXEL_W-1:0]     q01,
  input  logic [TEXEL_W-1:0]     q11,
  output logic [LEVEL_W-1:0]     woods,
  output logic [LEVEL_W-1:0]     wetness
);

  localparam int SUB_BITS = FRACTION_BITS + 1;
  localparam int LERP_W   = BYTE_W + SUB_BITS;
  localparam int ACC_W    = BYTE_W + 2 * SUB_BITS + 1;
  localparam int SHIFT    = 2 * SUB_BITS - 8;

  function automatic logic [LERP_W-1:0] lerp_byte(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b,
                                                  input logic [SUB_BITS-1:0] f);
    logic [LERP_W-1:0] wa;
    logic [LERP_W-1:0] wb;
    wa = LERP_W'(a) * ((LERP_W'(1) << SUB_BITS) - LERP_W'(f));
    wb = LERP_W'(b) * LERP_W'(f);
    return wa + wb;
  endfunction

  // Vertical blend, then round half up to eight fractional bits.
  function automatic logic [LEVEL_W-1:0] lerp_level(input logic [LERP_W-1:0] a,
                                                    input logic [LERP_W-1:0] b,
                                                    input logic [SUB_BITS-1:0] f);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(a) * ((ACC_W'(1) << SUB_BITS) - ACC_W'(f))
        + ACC_W'(b) * ACC_W'(f)
        + (ACC_W'(1) << (SHIFT - 1));
    return acc[SHIFT+LEVEL_W-1:SHIFT];
  endfunction

  logic [SUB_BITS-1:0] fc4;
  logic [SUB_BITS-1:0] fr4;
  logic [SUB_BITS-1:0] fr5;
  logic [LERP_W-1:0]   top_woods;
  logic [LERP_W-1:0]   bot_woods;
  logic [LERP_W-1:0]   top_wet;
  logic [LERP_W-1:0]   bot_wet;

  always_ff @(posedge clk) begin
    if (adv[STG_TEXEL]) begin
      fc4 <= frac_col;
      fr4 <= frac_row;
    end
    if (adv[STG_LERP]) begin
      fr5       <= fr4;
      top_woods <= lerp_byte(q00[BYTE_W-1:0], q10[BYTE_W-1:0], fc4);
      bot_woods <= lerp_byte(q01[BYTE_W-1:0], q11[BYTE_W-1:0], fc4);
      top_wet   <= lerp_byte(q00[TEXEL_W-1:BYTE_W], q10[TEXEL_W-1:BYTE_W], fc4);
      bot_wet   <= lerp_byte(q01[TEXEL_W-1:BYTE_W], q11[TEXEL_W-1:BYTE_W], fc4);
    end
    if (adv[STG_OUT]) begin
      woods   <= lerp_level(top_woods, bot_woods, fr5);
      wetness <= lerp_level(top_wet, bot_wet, fr5);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bilinear_cover_map_sampler_core.sv
`default_nettype none

// Channel   Kind        Direction  Beat carries
// item      valid/ready in         action, texel_index, woods_in, wet_in, column_pos, row_pos
// result    valid/ready out        woods, wetness (8.8 byte levels)
// apb       APB write   in         cover_columns at 0x0, cover_rows at 0x4
//
// One item per clock unless the result stalls. A sample passes the floor, wrap, address,
// texel, lerp and output stages. The store keeps two copies with two read ports each, so
// all four texels of a sample are read together; a load writes both in the address stage.
// Reset empties the pipeline and restores the size registers; store contents stay undefined.
// Each stage advances when it is empty or the next one is empty or advancing, so a stalled
// result holds in the output stage while bubbles upstream keep filling.

module bilinear_cover_map_sampler_core import bcms_pkg::*; #(
  parameter int COLUMN_BITS   = COLUMN_BITS_DEF,
  parameter int ROW_BITS      = ROW_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bcms_item_if.sink             item,
  bcms_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ADDR_W = COLUMN_BITS + ROW_BITS;

  logic [STAGES-1:0]               valid;
  logic [STAGES-1:0]               adv;
  logic [COLUMN_BITS:0]            cols;
  logic [ROW_BITS-1:0]             rows_last;
  logic [ROW_BITS+FRACTION_BITS:0] row_limit;
  logic                            is_load;
  logic [ADDR_W-1:0]               addr00;
  logic [ADDR_W-1:0]               addr10;
  logic [ADDR_W-1:0]               addr01;
  logic [ADDR_W-1:0]               addr11;
  logic [FRACTION_BITS:0]          frac_col;
  logic [FRACTION_BITS:0]          frac_row;
  logic [TEXEL_W-1:0]              texel_data;
  logic [TEXEL_W-1:0]              q00;
  logic [TEXEL_W-1:0]              q10;
  logic [TEXEL_W-1:0]              q01;
  logic [TEXEL_W-1:0]              q11;

  // A load leaves the pipeline after the address stage, so it never waits on the texel stage.
  always_comb begin
    adv[STG_OUT] = !valid[STG_OUT] || result.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      if (k == STG_ADDR) begin
        adv[k] = !valid[k] || is_load || adv[k+1];
      end else begin
        adv[k] = !valid[k] || adv[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[STG_FLOOR]) begin
        valid[STG_FLOOR] <= item.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1] && !(k == STG_TEXEL && is_load);
        end
      end
    end
  end

  assign item.ready   = adv[STG_FLOOR];
  assign result.valid = valid[STG_OUT];

  bcms_cfg #(
    .COLUMN_BITS   (COLUMN_BITS),
    .ROW_BITS      (ROW_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cols      (cols),
    .rows_last (rows_last),
    .row_limit (row_limit)
  );

  bcms_coord #(
    .COLUMN_BITS   (COLUMN_BITS),
    .ROW_BITS      (ROW_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_coord (
    .clk         (clk),
    .adv         (adv),
    .action      (item.action),
    .texel_index (item.texel_index),
    .woods_in    (item.woods_in),
    .wet_in      (item.wet_in),
    .column_pos  (item.column_pos),
    .row_pos     (item.row_pos),
    .cols        (cols),
    .rows_last   (rows_last),
    .row_limit   (row_limit),
    .is_load     (is_load),
    .addr00      (addr00),
    .addr10      (addr10),
    .addr01      (addr01),
    .addr11      (addr11),
    .frac_col    (frac_col),
    .frac_row    (frac_row),
    .texel_data  (texel_data)
  );

  bcms_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (valid[STG_ADDR] && is_load && adv[STG_ADDR]),
    .rd_en   (adv[STG_TEXEL]),
    .addr00  (addr00),
    .addr10  (addr10),
    .addr01  (addr01),
    .addr11  (addr11),
    .wr_data (texel_data),
    .q00     (q00),
    .q10     (q10),
    .q01     (q01),
    .q11     (q11)
  );

  bcms_blend #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_blend (
    .clk      (clk),
    .adv      (adv),
    .frac_col (frac_col),
    .frac_row (frac_row),
    .q00      (q00),
    .q10      (q10),
    .q01      (q01),
    .q11      (q11),
    .woods    (result.woods),
    .wetness  (result.wetness)
  );

  a_reset_empties: assert property (@(posedge clk) rst |=> valid == '0)
    else $error("pipeline not empty after reset");

  a_full_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    (&valid && !is_load && !result.ready) |-> !item.ready)
    else $error("item accepted while every stage is full and the result is stalled");

  a_load_gives_no_result: assert property (@(posedge clk) disable iff (rst)
    (valid[STG_ADDR] && is_load && adv[STG_TEXEL]) |=> !valid[STG_TEXEL])
    else $error("load beat reached the texel stage");

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb import bcms_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUB_BITS       = FRACTION_BITS_DEF + 1;
  localparam int ONE            = 1 << SUB_BITS;
  localparam int STORE_DEPTH    = 1 << IDX_W;
  localparam int TOTAL_BEATS    = 1250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;

  typedef struct {
    action_e                 action;
    logic [IDX_W-1:0]        index;
    logic [BYTE_W-1:0]       woods;
    logic [BYTE_W-1:0]       wet;
    logic signed [POS_W-1:0] cpos;
    logic signed [POS_W-1:0] rpos;
  } beat_t;

  typedef struct {
    logic [LEVEL_W-1:0] woods;
    logic [LEVEL_W-1:0] wetness;
  } levels_t;

  // Texel addresses in the order top-left, top-right, bottom-left, bottom-right.
  typedef struct {
    logic [3:0][IDX_W-1:0] addr;
    int unsigned           fc;
    int unsigned           fr;
  } footprint_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  bcms_item_if   item_ch ();
  bcms_result_if result_ch ();

  bilinear_cover_map_sampler_core DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [TEXEL_W-1:0] texel_map [0:STORE_DEPTH-1];
  bit                 texel_loaded [0:STORE_DEPTH-1];
  logic [REG_W-1:0]   columns_reg = COVER_COLUMNS_RST;
  logic [REG_W-1:0]   rows_reg = COVER_ROWS_RST;
  levels_t            pending_levels [$];

  int  mismatches = 0;
  int  beats_sent = 0;
  int  quiet_cycles = 0;
  int  sink_hold_cycles = 0;
  int  sink_stall_cycles = 0;
  bit  sink_idling = 1'b1;
  bit  source_idling = 1'b1;

  function automatic int columns_in_use();
    int v;
    v = int'(columns_reg);
    if (v < 1) v = 1;
    if (v > (1 << COLUMN_BITS_DEF)) v = 1 << COLUMN_BITS_DEF;
    return v;
  endfunction

  function automatic int rows_in_use();
    int v;
    v = int'(rows_reg);
    if (v < 1) v = 1;
    if (v > (1 << ROW_BITS_DEF)) v = 1 << ROW_BITS_DEF;
    return v;
  endfunction

  function automatic int wrap_column(input int cc, input int cols);
    int x;
    x = cc;
    if (x < 0) x = x + cols;
    else if (x >= cols) x = x - cols;
    if (x < 0) x = 0;
    if (x >= cols) x = cols - 1;
    return x;
  endfunction

  function automatic footprint_t locate(input logic signed [POS_W-1:0] cpos,
                                        input logic signed [POS_W-1:0] rpos);
    footprint_t fp;
    int cols, rows, c, r, c0, r0, x0, x1, y1;
    cols = columns_in_use();
    rows = rows_in_use();
    c = int'(cpos);
    r = int'(rpos);
    if (r < 0) r = 0;
    if (r > (rows - 1) * ONE) r = (rows - 1) * ONE;
    fp.fc = c & (ONE - 1);
    fp.fr = r & (ONE - 1);
    c0 = c >>> SUB_BITS;
    r0 = r >>> SUB_BITS;
    x0 = wrap_column(c0, cols);
    x1 = wrap_column(c0 + 1, cols);
    y1 = (r0 + 1 > rows - 1) ? rows - 1 : r0 + 1;
    fp.addr[0] = IDX_W'(r0 * cols + x0);
    fp.addr[1] = IDX_W'(r0 * cols + x1);
    fp.addr[2] = IDX_W'(y1 * cols + x0);
    fp.addr[3] = IDX_W'(y1 * cols + x1);
    return fp;
  endfunction

  function automatic logic [LEVEL_W-1:0] blend_levels(input logic [3:0][BYTE_W-1:0] v,
                                                      input int unsigned fc,
                                                      input int unsigned fr);
    longint unsigned top, bot, acc;
    top = longint'(v[0]) * (ONE - fc) + longint'(v[1]) * fc;
    bot = longint'(v[2]) * (ONE - fc) + longint'(v[3]) * fc;
    acc = top * (ONE - fr) + bot * fr;
    return LEVEL_W'((acc + (64'd1 << (2 * SUB_BITS - 9))) >> (2 * SUB_BITS - 8));
  endfunction

  function automatic levels_t predict_levels(input logic signed [POS_W-1:0] cpos,
                                             input logic signed [POS_W-1:0] rpos);
    footprint_t fp;
    levels_t lv;
    logic [3:0][BYTE_W-1:0] woods_b, wet_b;
    fp = locate(cpos, rpos);
    for (int k = 0; k < 4; k++) begin
      woods_b[k] = texel_map[fp.addr[k]][7:0];
      wet_b[k]   = texel_map[fp.addr[k]][15:8];
    end
    lv.woods   = blend_levels(woods_b, fp.fc, fp.fr);
    lv.wetness = blend_levels(wet_b, fp.fc, fp.fr);
    return lv;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.action = action_e'($urandom_range(0, 1));
    b.index  = IDX_W'($urandom);
    b.woods  = BYTE_W'($urandom);
    b.wet    = BYTE_W'($urandom);
    b.cpos   = POS_W'($urandom);
    b.rpos   = POS_W'($urandom);
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_beat(input beat_t b);
    if (source_idling && $urandom_range(0, 9) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= b.action;
    item_ch.texel_index <= b.index;
    item_ch.woods_in    <= b.woods;
    item_ch.wet_in      <= b.wet;
    item_ch.column_pos  <= b.cpos;
    item_ch.row_pos     <= b.rpos;
    do @(posedge clk); while (!item_ch.ready);
    if (b.action == ACT_LOAD) begin
      texel_map[b.index]    = {b.wet, b.woods};
      texel_loaded[b.index] = 1'b1;
    end else begin
      pending_levels.insert(pending_levels.size(), predict_levels(b.cpos, b.rpos));
    end
    beats_sent++;
  endtask

  task automatic load_texel(input int addr, input int woods, input int wet);
    beat_t b;
    b = random_beat();
    b.action = ACT_LOAD;
    b.index  = IDX_W'(addr);
    b.woods  = BYTE_W'(woods);
    b.wet    = BYTE_W'(wet);
    send_beat(b);
  endtask

  // Any texel that the sample would touch and that holds nothing yet gets a load first.
  task automatic sample_at(input logic signed [POS_W-1:0] cpos,
                           input logic signed [POS_W-1:0] rpos);
    footprint_t fp;
    beat_t b;
    fp = locate(cpos, rpos);
    for (int k = 0; k < 4; k++) begin
      if (!texel_loaded[fp.addr[k]])
        load_texel(fp.addr[k], $urandom_range(0, 255), $urandom_range(0, 255));
    end
    b = random_beat();
    b.action = ACT_SAMPLE;
    b.cpos   = cpos;
    b.rpos   = rpos;
    send_beat(b);
  endtask

  task automatic drain_pipeline();
    item_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_e idx, input logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(APB_DATA_W - REG_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COLUMNS) columns_reg = value;
    else rows_reg = value;
  endtask

  task automatic set_map_size(input int cols, input int rows);
    drain_pipeline();
    apb_write(REG_COLUMNS, REG_W'(cols));
    apb_write(REG_ROWS, REG_W'(rows));
  endtask

  task automatic run_mixed_traffic(input int beats);
    int start, pick, cp, rp;
    beat_t b;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        b = random_beat();
        b.action = ACT_LOAD;
        if (pick == 0)
          b.index = IDX_W'($urandom_range(0, columns_in_use() * rows_in_use() - 1));
        send_beat(b);
      end else if (pick < 9) begin
        cp = int'($urandom_range(0, columns_in_use() * ONE + 2 * ONE - 1)) - ONE;
        rp = int'($urandom_range(0, rows_in_use() * ONE + 2 * ONE - 1)) - ONE;
        sample_at(POS_W'(cp), POS_W'(rp));
      end else begin
        sample_at(POS_W'($urandom), POS_W'($urandom));
      end
    end
  endtask

  task automatic test_reset_size_corners();
    load_texel(0, 255, 0);
    load_texel(1, 0, 255);
    load_texel(512, 255, 255);
    load_texel(513, 0, 0);
    load_texel(STORE_DEPTH - 1, 128, 1);
    load_texel(511, 17, 240);
    sample_at(20'sd0, 20'sd0);
    sample_at(20'sd256, 20'sd256);
    sample_at(20'sd511, 20'sd511);
    sample_at(-20'sd1, 20'sd0);
    sample_at(-20'sd1, -20'sd524288);
    sample_at(20'sd524287, 20'sd524287);
    sample_at(-20'sd524288, 20'sd0);
    sample_at(20'sd0, 20'sd524287);
    sample_at(20'sd262143, 20'sd262143);
    sample_at(20'sd300000, 20'sd100);
    sample_at(-20'sd262149, 20'sd50);
    sample_at(20'sd262144, -20'sd300);
  endtask

  task automatic test_map_sizes();
    int col_settings [8] = '{1, 0, 1023, 512, 1, 2, 5, 511};
    int row_settings [8] = '{1, 0, 1023, 1, 512, 3, 2, 2};
    for (int k = 0; k < 8; k++) begin
      set_map_size(col_settings[k], row_settings[k]);
      sink_idling   = $urandom_range(0, 3) != 0;
      source_idling = $urandom_range(0, 3) != 0;
      run_mixed_traffic(45);
    end
  endtask

  task automatic test_stalled_output();
    set_map_size(16, 8);
    source_idling = 1'b0;
    sink_idling   = 1'b1;
    sink_hold_cycles = 400;
    run_mixed_traffic(60);
  endtask

  task automatic test_random_stream();
    int extremes [4] = '{0, 1, 512, 1023};
    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 4) == 0)
        set_map_size(extremes[$urandom_range(0, 3)], extremes[$urandom_range(0, 3)]);
      else
        set_map_size($urandom_range(1, 40), $urandom_range(1, 40));
      if (TOTAL_BEATS - beats_sent <= 300) begin
        source_idling = 1'b0;
        sink_idling   = 1'b0;
      end else begin
        source_idling = $urandom_range(0, 3) != 0;
        sink_idling   = $urandom_range(0, 3) != 0;
      end
      run_mixed_traffic(150);
    end
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        result_ch.ready <= 1'b0;
      end else if (sink_stall_cycles > 0) begin
        sink_stall_cycles--;
        result_ch.ready <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 11) == 0) begin
        sink_stall_cycles = $urandom_range(0, 16);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    levels_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (woods %0d wetness %0d)",
                                  result_ch.woods, result_ch.wetness));
      end else begin
        want = pending_levels.pop_front();
        if (result_ch.woods !== want.woods)
          report_mismatch($sformatf("woods got %0d expected %0d",
                                    result_ch.woods, want.woods));
        if (result_ch.wetness !== want.wetness)
          report_mismatch($sformatf("wetness got %0d expected %0d",
                                    result_ch.wetness, want.wetness));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL bilinear_cover_map_sampler_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.action      <= ACT_LOAD;
    item_ch.texel_index <= '0;
    item_ch.woods_in    <= '0;
    item_ch.wet_in      <= '0;
    item_ch.column_pos  <= '0;
    item_ch.row_pos     <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_size_corners();
    test_map_sizes();
    test_stalled_output();
    test_random_stream();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("PASS bilinear_cover_map_sampler_core");
    end else begin
      $display("FAIL bilinear_cover_map_sampler_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
